FILE: rtl/sssp_pkg.sv
package sssp_pkg;

	// default sizes handed to the top level
	localparam int MAX_NODES_DEF   = 32;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int DIST_BITS_DEF   = 24;

	// command field
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_POP,
		ST_ROW,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

endpackage

FILE: rtl/single_source_shortest_path.sv
// channel | direction | handshake              | word
// --------+-----------+------------------------+--------------------------------------
// cfg     | in        | cfg_valid / cfg_ready  | cfg_data (node_count)
// in      | in        | in_valid / in_stall    | op, src_node, dst_node, weight
// out     | out       | out_valid / out_stall  | node_index, distance, reachable, last
//
// an edge write is taken in ST_IDLE; a clear sweeps every edge matrix row to zero in ST_CLEAR
// after reset the same row sweep runs before the first command word is taken
// a run passes through ST_INIT, then for each node taken off the queue reads its row, scans the
// columns through the distance memory port and drains the relax stage; once the queue is found
// empty it reads and emits one result word per node from node two upwards (up to node_count)
// the single read port of the distance memory sets the column rate of one per cycle
// a result waits in the output register while out_stall is high; the scan does not stop

module single_source_shortest_path #(
	parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF,
	parameter int DIST_BITS   = sssp_pkg::DIST_BITS_DEF,
	localparam int NODE_W     = $clog2(MAX_NODES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [NODE_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [sssp_pkg::OP_W-1:0] op,
	input  logic [NODE_W-1:0]         src_node,
	input  logic [NODE_W-1:0]         dst_node,
	input  logic [WEIGHT_BITS-1:0]    weight,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [NODE_W-1:0]         node_index,
	output logic [DIST_BITS-1:0]      distance,
	output logic                      reachable,
	output logic                      last
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int ROW_W = MAX_NODES * WEIGHT_BITS;
	localparam int SUM_W = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
	localparam logic [NODE_W-1:0]    MAX_N    = NODE_W'(MAX_NODES);
	localparam logic [NODE_W-1:0]    MIN_N    = NODE_W'(2);
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(MAX_NODES - 1);
	localparam logic [DIST_BITS-1:0] D_MAX    = '1;

	// edge matrix, one row per source node, and best distance per node
	logic [ROW_W-1:0]     edge_mem [MAX_NODES];
	logic [DIST_BITS-1:0] best_mem [MAX_NODES];
	logic [ROW_W-1:0]     row_q;
	logic [DIST_BITS-1:0] best_rd_q;

	sssp_pkg::state_t state_q, state_d;

	logic [NODE_W-1:0]    node_count_q;
	logic [IDX_W-1:0]     clr_row_q;
	logic [IDX_W-1:0]     nm1_q;
	logic [IDX_W-1:0]     col_q;
	logic [IDX_W-1:0]     emit_q;
	logic [DIST_BITS-1:0] dist_here_q;

	// relaxation stage
	logic                   vld_s1;
	logic [IDX_W-1:0]       col_s1;
	logic [WEIGHT_BITS-1:0] w_s1;

	// work queue and per node flags
	logic [IDX_W-1:0]     queue_q [MAX_NODES];
	logic [IDX_W-1:0]     head_q, tail_q;
	logic [NODE_W-1:0]    count_q;
	logic [MAX_NODES-1:0] reached_q, queued_q;

	// output register
	logic                 out_valid_q;
	logic [NODE_W-1:0]    node_index_q;
	logic [DIST_BITS-1:0] distance_q;
	logic                 reachable_q, last_q;

	logic                   accept, slot_free, edge_we;
	logic [NODE_W-1:0]      n_eff;
	logic [IDX_W-1:0]       nm1, pop_node;
	logic [WEIGHT_BITS-1:0] lane_w;
	logic [SUM_W-1:0]       sum;
	logic [DIST_BITS-1:0]   sat;
	logic                   upd, enq;

	// sequencer controls
	logic               best_re, row_re, pop, init, issue, emit_load;
	logic [IDX_W-1:0]   best_ra;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != sssp_pkg::ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign slot_free  = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign node_index = node_index_q;
	assign distance   = distance_q;
	assign reachable  = reachable_q;
	assign last       = last_q;

	// nodes in use, clamped to the legal range
	always_comb begin
		if (node_count_q < MIN_N) begin
			n_eff = MIN_N;
		end else if (node_count_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = node_count_q;
		end
	end
	assign nm1 = IDX_W'(n_eff - NODE_W'(1));

	assign edge_we = accept && (op == sssp_pkg::OP_WRITE)
		&& (src_node != '0) && (src_node <= MAX_N)
		&& (dst_node != '0) && (dst_node <= MAX_N);

	assign pop_node = queue_q[head_q];
	assign lane_w   = row_q[col_q*WEIGHT_BITS +: WEIGHT_BITS];

	// relax one edge: saturating sum and improvement test
	assign sum = SUM_W'(dist_here_q) + SUM_W'(w_s1);
	assign sat = (sum > SUM_W'(D_MAX)) ? D_MAX : sum[DIST_BITS-1:0];
	assign upd = vld_s1 && (w_s1 != '0) && (!reached_q[col_s1] || (sat < best_rd_q));
	assign enq = upd && !queued_q[col_s1];

	// next state and controls
	always_comb begin
		state_d   = state_q;
		best_re   = 1'b0;
		best_ra   = '0;
		row_re    = 1'b0;
		pop       = 1'b0;
		init      = 1'b0;
		issue     = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			sssp_pkg::ST_CLEAR: begin
				if (clr_row_q == LAST_IDX) state_d = sssp_pkg::ST_IDLE;
			end
			sssp_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						sssp_pkg::OP_RUN:   state_d = sssp_pkg::ST_INIT;
						sssp_pkg::OP_CLEAR: state_d = sssp_pkg::ST_CLEAR;
						default:            state_d = sssp_pkg::ST_IDLE;
					endcase
				end
			end
			sssp_pkg::ST_INIT: begin
				init    = 1'b1;
				state_d = sssp_pkg::ST_POP;
			end
			sssp_pkg::ST_POP: begin
				if (count_q == '0) begin
					state_d = sssp_pkg::ST_EMIT_RD;
				end else begin
					pop     = 1'b1;
					row_re  = 1'b1;
					best_re = 1'b1;
					best_ra = pop_node;
					state_d = sssp_pkg::ST_ROW;
				end
			end
			sssp_pkg::ST_ROW: begin
				state_d = sssp_pkg::ST_SCAN;
			end
			sssp_pkg::ST_SCAN: begin
				issue   = 1'b1;
				best_re = 1'b1;
				best_ra = col_q;
				if (col_q == nm1_q) state_d = sssp_pkg::ST_DRAIN;
			end
			sssp_pkg::ST_DRAIN: begin
				state_d = sssp_pkg::ST_POP;
			end
			sssp_pkg::ST_EMIT_RD: begin
				best_re = 1'b1;
				best_ra = emit_q;
				state_d = sssp_pkg::ST_EMIT_OUT;
			end
			sssp_pkg::ST_EMIT_OUT: begin
				if (slot_free) begin
					emit_load = 1'b1;
					state_d   = (emit_q == nm1_q) ? sssp_pkg::ST_IDLE : sssp_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = sssp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sssp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= MAX_N;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// edge matrix: lane write, row sweep, row read
	always_ff @(posedge clk) begin
		if (state_q == sssp_pkg::ST_CLEAR) begin
			edge_mem[clr_row_q] <= '0;
		end else if (edge_we) begin
			edge_mem[IDX_W'(src_node - NODE_W'(1))]
				[IDX_W'(dst_node - NODE_W'(1))*WEIGHT_BITS +: WEIGHT_BITS] <= weight;
		end
	end

	always_ff @(posedge clk) begin
		if (row_re) row_q <= edge_mem[pop_node];
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (init) begin
			best_mem[0] <= '0;
		end else if (upd) begin
			best_mem[col_s1] <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (best_re) best_rd_q <= best_mem[best_ra];
	end

	// sweep, scan and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
			nm1_q     <= '0;
			col_q     <= '0;
			emit_q    <= '0;
		end else begin
			if (state_q == sssp_pkg::ST_CLEAR) begin
				clr_row_q <= (clr_row_q == LAST_IDX) ? '0 : clr_row_q + IDX_W'(1);
			end
			if (accept && (op == sssp_pkg::OP_RUN)) nm1_q <= nm1;
			if (state_q == sssp_pkg::ST_ROW) begin
				col_q <= '0;
			end else if (issue) begin
				col_q <= col_q + IDX_W'(1);
			end
			if (state_q == sssp_pkg::ST_POP && count_q == '0) begin
				emit_q <= IDX_W'(1);
			end else if (emit_load) begin
				emit_q <= emit_q + IDX_W'(1);
			end
		end
	end

	// source distance of the row under scan and the relax stage
	always_ff @(posedge clk) begin
		if (state_q == sssp_pkg::ST_ROW) dist_here_q <= best_rd_q;
		col_s1 <= col_q;
		w_s1   <= lane_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	// queue entries
	always_ff @(posedge clk) begin
		if (init) begin
			queue_q[0] <= '0;
		end else if (enq) begin
			queue_q[tail_q] <= col_s1;
		end
	end

	// queue pointers and node flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			reached_q <= '0;
			queued_q  <= '0;
		end else if (init) begin
			head_q    <= '0;
			tail_q    <= IDX_W'(1);
			count_q   <= NODE_W'(1);
			reached_q <= MAX_NODES'(1);
			queued_q  <= MAX_NODES'(1);
		end else begin
			if (pop) begin
				head_q             <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
				count_q            <= count_q - NODE_W'(1);
				queued_q[pop_node] <= 1'b0;
			end
			if (upd) reached_q[col_s1] <= 1'b1;
			if (enq) begin
				tail_q           <= (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
				count_q          <= count_q + NODE_W'(1);
				queued_q[col_s1] <= 1'b1;
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			node_index_q <= NODE_W'(emit_q) + NODE_W'(1);
			distance_q   <= reached_q[emit_q] ? best_rd_q : '0;
			reachable_q  <= reached_q[emit_q];
			last_q       <= (emit_q == nm1_q);
		end
	end

	// pending marks and queue fill agree
	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queued_q) == count_q)
		else $error("pending marks do not match queue fill");

	// a pending node has always been reached
	a_queued_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(queued_q & ~reached_q) == '0)
		else $error("node pending without a distance");

	// relax stage only follows a column issue
	a_relax_window: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == sssp_pkg::ST_SCAN || state_q == sssp_pkg::ST_DRAIN))
		else $error("relax stage active outside a row scan");

	// the final result word closes the run
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_q == nm1_q) |=> (state_q == sssp_pkg::ST_IDLE && out_valid_q && last_q))
		else $error("run did not end on the final word");

endmodule

FILE: tb/sv/single_source_shortest_path_tb.sv
module single_source_shortest_path_tb;

	localparam int MAX_NODES   = sssp_pkg::MAX_NODES_DEF;
	localparam int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF;
	localparam int DIST_BITS   = sssp_pkg::DIST_BITS_DEF;
	localparam int NODE_W      = $clog2(MAX_NODES + 1);

	typedef logic [sssp_pkg::OP_W-1:0] op_code_t;

	localparam op_code_t OP_SPARE = 2'd3;
	localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_BITS) - 1;

	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = MAX_NODES + 8;
	localparam int RANDOM_WORDS  = 90;

	// one distance word as it leaves the block
	typedef struct packed {
		logic [NODE_W-1:0]    node;
		logic [DIST_BITS-1:0] dval;
		logic                 rch;
		logic                 lst;
	} dist_report_t;

	// one line of the directed sequence
	typedef struct packed {
		logic                   is_cfg;
		logic [NODE_W-1:0]      cfg_val;
		op_code_t               op;
		logic [NODE_W-1:0]      src;
		logic [NODE_W-1:0]      dst;
		logic [WEIGHT_BITS-1:0] cost;
		logic                   typed;
		dist_report_t           want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [NODE_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	op_code_t               op;
	logic [NODE_W-1:0]      src_node;
	logic [NODE_W-1:0]      dst_node;
	logic [WEIGHT_BITS-1:0] weight;
	logic                   out_valid;
	logic                   out_stall;
	logic [NODE_W-1:0]      node_index;
	logic [DIST_BITS-1:0]   distance;
	logic                   reachable;
	logic                   last;

	// predictor state
	logic [WEIGHT_BITS-1:0] edge_cost [MAX_NODES][MAX_NODES];
	logic [NODE_W-1:0]      model_node_count;
	dist_report_t           pending_reports [$];

	int          mismatches;
	int          useful_words;
	int          stall_left;
	bit          sender_calm;
	bit          receiver_calm;
	longint      cycle_count;
	longint      cycle_budget;
	dist_report_t head_report;
	plan_row_t   plan [$];

	single_source_shortest_path uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.src_node   (src_node),
		.dst_node   (dst_node),
		.weight     (weight),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.node_index (node_index),
		.distance   (distance),
		.reachable  (reachable),
		.last       (last)
	);

	// clock, period 8
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// node count clamped into the usable range
	function automatic int active_nodes();
		if (model_node_count < 2) return 2;
		if (model_node_count > MAX_NODES) return MAX_NODES;
		return int'(model_node_count);
	endfunction

	// queue-based relaxation from node one, returns the number of nodes taken off the queue
	function automatic int relax_from_node_one(input int span, input bit publish);
		logic [DIST_BITS-1:0] best [MAX_NODES];
		bit                   seen [MAX_NODES];
		bit                   pending [MAX_NODES];
		int                   frontier [$];
		int                   pops;
		int                   here;
		longint unsigned      sum;
		dist_report_t         rep;
		pops = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			best[i]    = '0;
			seen[i]    = 1'b0;
			pending[i] = 1'b0;
		end
		seen[0]    = 1'b1;
		pending[0] = 1'b1;
		frontier.push_back(0);
		while (frontier.size() > 0) begin
			here = frontier.pop_front();
			pending[here] = 1'b0;
			pops++;
			for (int there = 0; there < span; there++) begin
				if (edge_cost[here][there] != '0) begin
					sum = best[here];
					sum += edge_cost[here][there];
					if (sum > DIST_LIMIT) sum = DIST_LIMIT;
					if (!seen[there] || sum < best[there]) begin
						best[there] = sum[DIST_BITS-1:0];
						seen[there] = 1'b1;
						if (!pending[there] && frontier.size() < MAX_NODES) begin
							frontier.push_back(there);
							pending[there] = 1'b1;
						end
					end
				end
			end
		end
		// one word per node from two upwards
		if (publish) begin
			for (int i = 1; i < span; i++) begin
				rep.node = NODE_W'(i + 1);
				rep.dval = seen[i] ? best[i] : '0;
				rep.rch  = seen[i];
				rep.lst  = (i + 1 == span);
				pending_reports.push_back(rep);
			end
		end
		return pops;
	endfunction

	// update the predictor with an accepted command word
	task automatic track_command(input op_code_t w_op, input logic [NODE_W-1:0] w_src,
			input logic [NODE_W-1:0] w_dst, input logic [WEIGHT_BITS-1:0] w_cost,
			input bit typed, input dist_report_t want);
		int span;
		int pops;
		cycle_budget += 16;
		case (w_op)
			sssp_pkg::OP_WRITE: begin
				if (w_src >= 1 && w_src <= MAX_NODES && w_dst >= 1 && w_dst <= MAX_NODES) begin
					edge_cost[w_src-1][w_dst-1] = w_cost;
					useful_words++;
				end
			end
			sssp_pkg::OP_CLEAR: begin
				for (int i = 0; i < MAX_NODES; i++)
					for (int j = 0; j < MAX_NODES; j++)
						edge_cost[i][j] = '0;
				cycle_budget += MAX_NODES + 2;
				useful_words++;
			end
			sssp_pkg::OP_RUN: begin
				span = active_nodes();
				pops = relax_from_node_one(span, !typed);
				if (typed) pending_reports.push_back(want);
				cycle_budget += 4 + pops * (span + 3) + (span - 1) * 16;
				useful_words++;
			end
			default: begin
				// spare code, ignored by the block
			end
		endcase
	endtask

	// hand one word to the block, with a random gap ahead of it
	task automatic send_word(input op_code_t w_op, input logic [NODE_W-1:0] w_src,
			input logic [NODE_W-1:0] w_dst, input logic [WEIGHT_BITS-1:0] w_cost,
			input bit typed, input dist_report_t want);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= w_op;
		src_node <= w_src;
		dst_node <= w_dst;
		weight   <= w_cost;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_command(w_op, w_src, w_dst, w_cost, typed, want);
	endtask

	// hold the input until every distance word is back and the block has settled
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cycle_budget += SETTLE_CYCLES;
	endtask

	// node count register write, only with the block idle
	task automatic program_node_count(input logic [NODE_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_node_count = value;
		cycle_budget += 16;
		cfg_valid <= 1'b0;
	endtask

	function automatic plan_row_t mk_word(input op_code_t w_op,
			input logic [NODE_W-1:0] w_src, input logic [NODE_W-1:0] w_dst,
			input logic [WEIGHT_BITS-1:0] w_cost);
		plan_row_t r;
		r        = '0;
		r.op     = w_op;
		r.src    = w_src;
		r.dst    = w_dst;
		r.cost   = w_cost;
		return r;
	endfunction

	function automatic plan_row_t mk_cfg(input logic [NODE_W-1:0] value);
		plan_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_val = value;
		return r;
	endfunction

	// run on a two-node graph: a single word for node two, flagged last
	function automatic plan_row_t mk_check(input logic [DIST_BITS-1:0] want_dist, input logic rch);
		plan_row_t r;
		r       = '0;
		r.op    = sssp_pkg::OP_RUN;
		r.typed = 1'b1;
		r.want  = '{node: NODE_W'(2), dval: want_dist, rch: rch, lst: 1'b1};
		return r;
	endfunction

	function automatic logic [NODE_W-1:0] pick_node_count();
		case ($urandom_range(0, 7))
			0:       return NODE_W'($urandom_range(0, 63));
			1:       return NODE_W'(MAX_NODES);
			default: return NODE_W'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] pick_edge_cost();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return WEIGHT_BITS'($urandom_range(0, 65535));
			default: return WEIGHT_BITS'($urandom_range(1, 20));
		endcase
	endfunction

	task automatic report_field(input string field, input longint want, input longint got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// receiver: check each accepted word and draw its stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, got node %0d distance %0d",
					$time, node_index, distance);
			end else begin
				head_report = pending_reports.pop_front();
				if (node_index !== head_report.node)
					report_field("node_index", head_report.node, node_index);
				if (distance !== head_report.dval)
					report_field("distance", head_report.dval, distance);
				if (reachable !== head_report.rch)
					report_field("reachable", head_report.rch, reachable);
				if (last !== head_report.lst)
					report_field("last", head_report.lst, last);
			end
			stall_left = receiver_calm ? 0 : $urandom_range(0, 12);
			if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (!receiver_calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12);
		end
		out_stall <= (stall_left != 0);
	end

	// watchdog, limit grows with the work handed to the block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4 * cycle_budget + 20000) begin
			$display("%0t: no progress, %0d words outstanding", $time, pending_reports.size());
			$display("** single_source_shortest_path: FAILED **");
			$finish;
		end
	end

	// reset, directed sequence, then random graphs
	initial begin
		int span;
		int edge_writes;
		int random_start;
		int hi;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		op            = sssp_pkg::OP_WRITE;
		src_node      = '0;
		dst_node      = '0;
		weight        = '0;
		out_stall     = 1'b0;
		stall_left    = 0;
		mismatches    = 0;
		useful_words  = 0;
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		cycle_count   = 0;
		cycle_budget  = RESET_CYCLES + MAX_NODES + 16;
		model_node_count = NODE_W'(MAX_NODES);
		for (int i = 0; i < MAX_NODES; i++)
			for (int j = 0; j < MAX_NODES; j++)
				edge_cost[i][j] = '0;

		// directed sequence
		plan.push_back(mk_word(sssp_pkg::OP_RUN, 0, 0, 0));
		plan.push_back(mk_cfg(2));
		plan.push_back(mk_check(0, 1'b0));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 2, 16'hFFFF));
		plan.push_back(mk_check(24'd65535, 1'b1));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 2, 0));
		plan.push_back(mk_check(0, 1'b0));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 0, 2, 5));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 63, 7));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 33, 2, 9));
		plan.push_back(mk_word(OP_SPARE, 63, 63, 16'hFFFF));
		plan.push_back(mk_check(0, 1'b0));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 2, 1));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 2, 9));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 3, 7));
		plan.push_back(mk_check(24'd9, 1'b1));
		plan.push_back(mk_cfg(0));
		plan.push_back(mk_check(24'd9, 1'b1));
		plan.push_back(mk_cfg(1));
		plan.push_back(mk_check(24'd9, 1'b1));
		plan.push_back(mk_cfg(63));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 2, 32, 100));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 32, 3, 4));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 32, 32, 1));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 3, 17, 42));
		plan.push_back(mk_word(sssp_pkg::OP_RUN, 21, 42, 16'h5A5A));
		plan.push_back(mk_word(sssp_pkg::OP_CLEAR, 0, 0, 0));
		plan.push_back(mk_word(sssp_pkg::OP_RUN, 0, 0, 0));
		plan.push_back(mk_cfg(33));
		plan.push_back(mk_word(sssp_pkg::OP_WRITE, 1, 32, 16'h5A5A));
		plan.push_back(mk_word(sssp_pkg::OP_RUN, 0, 0, 0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < plan.size(); r++) begin
			if (plan[r].is_cfg)
				program_node_count(plan[r].cfg_val);
			else
				send_word(plan[r].op, plan[r].src, plan[r].dst, plan[r].cost,
					plan[r].typed, plan[r].want);
		end

		// random graphs, each closed by a run
		random_start = useful_words;
		while (useful_words - random_start < RANDOM_WORDS) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) program_node_count(pick_node_count());
			if ($urandom_range(0, 3) == 0)
				send_word(sssp_pkg::OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
					WEIGHT_BITS'($urandom), 1'b0, '0);
			span = active_nodes();
			edge_writes = $urandom_range(1, (span < 12) ? 2 * span : 24);
			for (int k = 0; k < edge_writes; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(op_code_t'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 63)),
						NODE_W'($urandom_range(0, 63)), WEIGHT_BITS'($urandom_range(0, 65535)),
						1'b0, '0);
				end else begin
					hi = ($urandom_range(0, 7) == 0) ? MAX_NODES : span;
					send_word(sssp_pkg::OP_WRITE, NODE_W'($urandom_range(1, hi)),
						NODE_W'($urandom_range(1, hi)), pick_edge_cost(), 1'b0, '0);
				end
			end
			send_word(sssp_pkg::OP_RUN, NODE_W'($urandom), NODE_W'($urandom),
				WEIGHT_BITS'($urandom), 1'b0, '0);
		end

		wait_drained();
		if (mismatches == 0)
			$display("** single_source_shortest_path: PASSED **");
		else
			$display("** single_source_shortest_path: FAILED **");
		$finish;
	end

endmodule
